>>> sv/cpcm_pkg.sv
// Shared types, constants and table-generation functions for the cosine palette color map
package cpcm_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned MAXIT_W    = 16;
	localparam int unsigned ORDER_W    = 3;
	localparam int unsigned IN_W       = 16;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned COLOR_W    = 24;

	localparam logic [MAXIT_W-1:0] MAXIT_RESET = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_ITER = 2'd0,
		CFG_ORDER    = 2'd1
	} cfg_reg_t;

	typedef enum logic [ORDER_W-1:0] {
		ORD_ABC = 3'd0,
		ORD_ACB = 3'd1,
		ORD_CAB = 3'd2,
		ORD_CBA = 3'd3,
		ORD_BAC = 3'd4,
		ORD_BCA = 3'd5
	} order_t;

	localparam logic [63:0] TWOPI_Q30 = 64'h0000_0001_921F_B544;
	localparam logic [63:0] ONE_Q30   = 64'h0000_0000_4000_0000;
	localparam logic [63:0] CHAN_MAX  = 64'd255;

	localparam logic [63:0] COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
		64'd132, 64'd182};
	localparam logic [63:0] SIN_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156};

	function automatic logic signed [63:0] cos_q30(logic [63:0] t);
		logic [63:0] term;
		logic signed [63:0] sum;
		term = ONE_Q30;
		sum = $signed(ONE_Q30);
		for (int k = 0; k < 7; k++) begin
			term = (term * t) >> 30;
			term = (term * t) >> 30;
			term = term / COS_DIV[k];
			if (k[0] == 1'b0) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		return sum;
	endfunction

	function automatic logic signed [63:0] sin_q30(logic [63:0] t);
		logic [63:0] term;
		logic signed [63:0] sum;
		term = t;
		sum = $signed(t);
		for (int k = 0; k < 6; k++) begin
			term = (term * t) >> 30;
			term = (term * t) >> 30;
			term = term / SIN_DIV[k];
			if (k[0] == 1'b0) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		return sum;
	endfunction

	function automatic logic [CHAN_W-1:0] chan_value(logic [15:0] phase, int unsigned pb);
		logic [1:0] quad;
		logic [63:0] r;
		logic [63:0] t;
		logic signed [63:0] c;
		logic [63:0] prod;
		quad = 2'((64'(phase) >> (pb - 2)) & 64'd3);
		r = 64'(phase) & ((64'd1 << (pb - 2)) - 64'd1);
		t = (r * TWOPI_Q30) >> pb;
		unique case (quad)
			2'd0: c = cos_q30(t);
			2'd1: c = -sin_q30(t);
			2'd2: c = -cos_q30(t);
			default: c = sin_q30(t);
		endcase
		if (c > $signed(ONE_Q30)) begin
			c = $signed(ONE_Q30);
		end
		if (c < -$signed(ONE_Q30)) begin
			c = -$signed(ONE_Q30);
		end
		prod = CHAN_MAX * $unsigned($signed(ONE_Q30) - c);
		return CHAN_W'(prod >> 31);
	endfunction

endpackage

>>> sv/cpcm_div_step.sv
// One restoring-division step: produces one quotient bit per pipeline stage
module cpcm_div_step #(
	parameter int unsigned COUNT_BITS = 16,
	parameter int unsigned PHASE_BITS = 10,
	parameter int unsigned STEP       = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic [cpcm_pkg::MAXIT_W-1:0]        divisor,
	input  logic                                in_valid,
	input  logic [COUNT_BITS-1:0]               in_n,
	input  logic [cpcm_pkg::MAXIT_W-1:0]        in_rem,
	input  logic [PHASE_BITS-1:0]               in_quot,
	output logic                                valid_s1,
	output logic [COUNT_BITS-1:0]               n_s1,
	output logic [cpcm_pkg::MAXIT_W-1:0]        rem_s1,
	output logic [PHASE_BITS-1:0]               quot_s1
);

	logic                           nbit;
	logic [cpcm_pkg::MAXIT_W:0]     trial;
	logic [cpcm_pkg::MAXIT_W:0]     diff;
	logic                           ge;
	logic [cpcm_pkg::MAXIT_W-1:0]   rem_next;

	if (STEP < COUNT_BITS) begin : g_nbit
		assign nbit = in_n[COUNT_BITS-1-STEP];
	end else begin : g_zero
		assign nbit = 1'b0;
	end

	assign trial    = {in_rem, nbit};
	assign diff     = trial - {1'b0, divisor};
	assign ge       = trial >= {1'b0, divisor};
	assign rem_next = ge ? diff[cpcm_pkg::MAXIT_W-1:0] : trial[cpcm_pkg::MAXIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1    <= in_n;
			rem_s1  <= rem_next;
			quot_s1 <= {in_quot[PHASE_BITS-2:0], ge};
		end
	end

endmodule

>>> sv/cpcm_rom.sv
// Raised-cosine channel ROM with registered read, filled at elaboration
module cpcm_rom #(
	parameter int unsigned PHASE_BITS = 10
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [PHASE_BITS-1:0]         addr,
	output logic [cpcm_pkg::CHAN_W-1:0]   rd_data_q
);

	localparam int unsigned DEPTH = 2 ** PHASE_BITS;

	typedef logic [cpcm_pkg::CHAN_W-1:0] rom_t [DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < DEPTH; i++) begin
			r[i] = cpcm_pkg::chan_value(16'(i), PHASE_BITS);
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			rd_data_q <= ROM[addr];
		end
	end

endmodule

>>> sv/cosine_palette_color_map_core.sv
// Cosine palette color map: one iteration count in, one packed 24-bit color out per request.
// A new request is taken every cycle while the pipeline is not stalled: a restoring divider
// producing one quotient bit per stage forms count * 2^PHASE_BITS / max_iterations, three
// channel ROMs of 2^PHASE_BITS bytes are read with a registered port, and an output register
// applies the channel order. When a valid output is stalled the whole pipeline holds, so
// stall reaches the input in the same cycle.
// max_iterations of zero divides by one; channel_order codes 6 and 7 act as code 5.
module cosine_palette_color_map_core #(
	parameter int unsigned COUNT_BITS = 16,
	parameter int unsigned PHASE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cpcm_pkg::IN_W-1:0]           iter_count,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cpcm_pkg::COLOR_W-1:0]        packed_color,
	input  logic                                cfg_wr_en,
	input  logic [cpcm_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [cpcm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int unsigned W = COUNT_BITS + PHASE_BITS;

	logic [cpcm_pkg::MAXIT_W-1:0]   max_iter_q;
	logic [cpcm_pkg::ORDER_W-1:0]   order_q;
	logic [cpcm_pkg::MAXIT_W-1:0]   div_d;
	logic                           adv;

	logic                           valid_c [W+1];
	logic [COUNT_BITS-1:0]          n_c     [W+1];
	logic [cpcm_pkg::MAXIT_W-1:0]   rem_c   [W+1];
	logic [PHASE_BITS-1:0]          quot_c  [W+1];

	logic [PHASE_BITS-1:0]          addr_a;
	logic [PHASE_BITS-1:0]          addr_b;
	logic [PHASE_BITS-1:0]          addr_c;
	logic [cpcm_pkg::CHAN_W-1:0]    chan_a;
	logic [cpcm_pkg::CHAN_W-1:0]    chan_b;
	logic [cpcm_pkg::CHAN_W-1:0]    chan_c;
	logic                           rom_vld_q;
	logic [cpcm_pkg::COLOR_W-1:0]   color_next;
	logic                           out_vld_q;
	logic [cpcm_pkg::COLOR_W-1:0]   packed_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= cpcm_pkg::MAXIT_RESET;
			order_q    <= cpcm_pkg::ORD_ABC;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				cpcm_pkg::CFG_MAX_ITER: max_iter_q <= cfg_wdata;
				cpcm_pkg::CFG_ORDER:    order_q    <= cfg_wdata[cpcm_pkg::ORDER_W-1:0];
				default: ;
			endcase
		end
	end

	assign div_d    = (max_iter_q == '0) ? cpcm_pkg::MAXIT_W'(1) : max_iter_q;
	assign adv      = !out_vld_q || !out_stall;
	assign in_stall = !adv;

	if (COUNT_BITS >= cpcm_pkg::IN_W) begin : g_wide
		assign n_c[0] = COUNT_BITS'(iter_count);
	end else begin : g_narrow
		assign n_c[0] = iter_count[COUNT_BITS-1:0];
	end

	assign valid_c[0] = in_valid;
	assign rem_c[0]   = '0;
	assign quot_c[0]  = '0;

	for (genvar g = 0; g < W; g++) begin : g_div
		cpcm_div_step #(
			.COUNT_BITS (COUNT_BITS),
			.PHASE_BITS (PHASE_BITS),
			.STEP       (g)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.divisor  (div_d),
			.in_valid (valid_c[g]),
			.in_n     (n_c[g]),
			.in_rem   (rem_c[g]),
			.in_quot  (quot_c[g]),
			.valid_s1 (valid_c[g+1]),
			.n_s1     (n_c[g+1]),
			.rem_s1   (rem_c[g+1]),
			.quot_s1  (quot_c[g+1])
		);
	end

	assign addr_a = quot_c[W];
	assign addr_b = {quot_c[W][PHASE_BITS-2:0], 1'b0};
	assign addr_c = {quot_c[W][PHASE_BITS-3:0], 2'b00};

	cpcm_rom #(.PHASE_BITS(PHASE_BITS)) u_rom_a (
		.clk (clk), .en (adv), .addr (addr_a), .rd_data_q (chan_a)
	);
	cpcm_rom #(.PHASE_BITS(PHASE_BITS)) u_rom_b (
		.clk (clk), .en (adv), .addr (addr_b), .rd_data_q (chan_b)
	);
	cpcm_rom #(.PHASE_BITS(PHASE_BITS)) u_rom_c (
		.clk (clk), .en (adv), .addr (addr_c), .rd_data_q (chan_c)
	);

	always_comb begin
		unique case (order_q)
			cpcm_pkg::ORD_ABC: color_next = {chan_a, chan_b, chan_c};
			cpcm_pkg::ORD_ACB: color_next = {chan_a, chan_c, chan_b};
			cpcm_pkg::ORD_CAB: color_next = {chan_c, chan_a, chan_b};
			cpcm_pkg::ORD_CBA: color_next = {chan_c, chan_b, chan_a};
			cpcm_pkg::ORD_BAC: color_next = {chan_b, chan_a, chan_c};
			default:           color_next = {chan_b, chan_c, chan_a};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			rom_vld_q <= valid_c[W];
			out_vld_q <= rom_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			packed_color_q <= color_next;
		end
	end

	assign out_valid    = out_vld_q;
	assign packed_color = packed_color_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_c[W] |-> (rem_c[W] < div_d))
		else $error("divider remainder not below divisor");

	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (out_vld_q == $past(rom_vld_q)))
		else $error("output valid lost or invented on advance");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(rom_vld_q) && $stable(valid_c[W])))
		else $error("pipeline moved while output stalled");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr_en |=> ($stable(max_iter_q) && $stable(order_q)))
		else $error("configuration changed without a write");

endmodule
